### rtl/wormhole_xy_mesh_router_macros.svh
// assertion helpers for the checker file
`ifndef WORMHOLE_XY_MESH_ROUTER_MACROS_SVH
`define WORMHOLE_XY_MESH_ROUTER_MACROS_SVH

// same-cycle implication
`define WXY_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WXY_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wxy_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wxy_pkg;

    localparam int NPORTS         = 5;
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int FLIT_WIDTH_DEF = 16;

    // port codes, also the xy routing results
    localparam logic [2:0] PORT_EAST  = 3'd0;
    localparam logic [2:0] PORT_WEST  = 3'd1;
    localparam logic [2:0] PORT_NORTH = 3'd2;
    localparam logic [2:0] PORT_SOUTH = 3'd3;
    localparam logic [2:0] PORT_LOCAL = 3'd4;
    localparam logic [2:0] UNBOUND    = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_FWD  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // request opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // packet phase of a bound port
    localparam logic [1:0] PH_HDR  = 2'd0;
    localparam logic [1:0] PH_SIZE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUTER_X = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUTER_Y = 4'd1;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  in_port;
        logic [15:0] in_flit;
        logic [4:0]  out_full_mask;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        push_refused;
        logic [2:0]  out_port;
        logic [2:0]  src_port;
        logic [15:0] out_flit;
        logic        last;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       push;
        logic       rd_en;
        logic [2:0] port;
        logic       arb;
        logic       drive;
        logic       last;
        logic       none;
        logic       adv_prio;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       req_op;
        logic       out_free;
        logic [2:0] prio;
        logic [4:0] drive_mask;
    } sts_t;

endpackage

`default_nettype wire

### rtl/wxy_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wxy_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 80
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/wxy_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module wxy_dp #(
    parameter int FIFO_DEPTH = wxy_pkg::FIFO_DEPTH_DEF,
    parameter int FLIT_WIDTH = wxy_pkg::FLIT_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire wxy_pkg::req_t                    req,
    output wxy_pkg::rsp_t                         rsp,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    input  wire logic                             cfg_we,
    input  wire logic [wxy_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [3:0]                       cfg_data,
    input  wire wxy_pkg::cmd_t                    cmd,
    output wxy_pkg::sts_t                         sts
);

    localparam int NP = wxy_pkg::NPORTS;
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int MD = NP * FIFO_DEPTH;
    localparam int AW = $clog2(MD);

    logic [3:0]            router_x_reg;
    logic [3:0]            router_y_reg;
    wxy_pkg::req_t         item_reg;
    wxy_pkg::rsp_t         rsp_reg;
    logic                  rsp_valid_reg;
    logic [CW-1:0]         cnt_reg   [NP];
    logic [PW-1:0]         rptr_reg  [NP];
    logic [2:0]            bound_reg [NP];
    logic [1:0]            phase_reg [NP];
    logic [FLIT_WIDTH-1:0] left_reg  [NP];
    logic [2:0]            prio_reg;

    logic [FLIT_WIDTH-1:0] head;
    logic                  out_free;
    logic [2:0]            pp;
    logic                  push_ok;
    logic [CW:0]           wsum;
    logic [PW-1:0]         wpos;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [2:0]            target;
    logic                  taken;
    logic                  bind_ok;
    logic [4:0]            drive_mask;
    logic [2:0]            dp;
    logic [FLIT_WIDTH-1:0] left_dec;

    // xy route of a header flit
    function automatic logic [2:0] route_xy(input logic [FLIT_WIDTH-1:0] f,
                                            input logic [3:0] rx, input logic [3:0] ry);
        logic [3:0] tx;
        logic [3:0] ty;
        logic [2:0] r;
        tx = f[7:4];
        ty = f[3:0];
        if (rx == tx)
        begin
            if (ry == ty)
                r = wxy_pkg::PORT_LOCAL;
            else
                r = (ry > ty) ? wxy_pkg::PORT_SOUTH : wxy_pkg::PORT_NORTH;
        end
        else
        begin
            r = (rx > tx) ? wxy_pkg::PORT_WEST : wxy_pkg::PORT_EAST;
        end
        return r;
    endfunction

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // push write position
    assign pp      = item_reg.in_port;
    assign push_ok = (pp < 3'(NP)) && (cnt_reg[pp] < CW'(FIFO_DEPTH));
    assign wsum    = (CW+1)'(rptr_reg[pp]) + (CW+1)'(cnt_reg[pp]);
    assign wpos    = (wsum >= (CW+1)'(FIFO_DEPTH)) ? PW'(wsum - (CW+1)'(FIFO_DEPTH))
                                                   : PW'(wsum);
    assign waddr   = AW'(pp) * AW'(FIFO_DEPTH) + AW'(wpos);
    assign raddr   = AW'(cmd.port) * AW'(FIFO_DEPTH) + AW'(rptr_reg[cmd.port]);

    wxy_ram #(
        .WIDTH (FLIT_WIDTH),
        .DEPTH (MD)
    ) u_fifo_mem (
        .clk   (clk),
        .we    (cmd.push && push_ok),
        .waddr (waddr),
        .wdata (FLIT_WIDTH'(item_reg.in_flit)),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (head)
    );

    // arbitration for the round-robin port
    always_comb
    begin
        target = route_xy(head, router_x_reg, router_y_reg);
        taken  = 1'b0;
        for (int i = 0; i < NP; i++)
        begin
            if (bound_reg[i] == target)
                taken = 1'b1;
        end
        bind_ok = (cnt_reg[prio_reg] != '0) && (bound_reg[prio_reg] == wxy_pkg::UNBOUND)
                  && !taken;
    end

    // ports that move a flit this tick
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            drive_mask[i] = (bound_reg[i] != wxy_pkg::UNBOUND) && (cnt_reg[i] != '0)
                            && !item_reg.out_full_mask[bound_reg[i]];
        end
    end

    assign dp       = cmd.port;
    assign left_dec = left_reg[dp] - FLIT_WIDTH'(1);

    // configuration and request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_x_reg <= '0;
            router_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == wxy_pkg::CFG_ROUTER_X)
                router_x_reg <= cfg_data;
            else if (cfg_index == wxy_pkg::CFG_ROUTER_Y)
                router_y_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= req;
    end

    // per-port queue and binding state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
            begin
                cnt_reg[i]   <= '0;
                rptr_reg[i]  <= '0;
                bound_reg[i] <= wxy_pkg::UNBOUND;
                phase_reg[i] <= wxy_pkg::PH_HDR;
                left_reg[i]  <= '0;
            end
            prio_reg <= wxy_pkg::PORT_LOCAL;
        end
        else
        begin
            if (cmd.push && push_ok)
                cnt_reg[pp] <= cnt_reg[pp] + CW'(1);
            if (cmd.arb && bind_ok)
            begin
                bound_reg[prio_reg] <= target;
                phase_reg[prio_reg] <= wxy_pkg::PH_HDR;
            end
            if (cmd.drive)
            begin
                cnt_reg[dp]  <= cnt_reg[dp] - CW'(1);
                rptr_reg[dp] <= (rptr_reg[dp] == PW'(FIFO_DEPTH - 1)) ? '0
                                                                      : rptr_reg[dp] + PW'(1);
                case (phase_reg[dp])
                    wxy_pkg::PH_HDR:
                    begin
                        phase_reg[dp] <= wxy_pkg::PH_SIZE;
                    end
                    wxy_pkg::PH_SIZE:
                    begin
                        phase_reg[dp] <= wxy_pkg::PH_BODY;
                        left_reg[dp]  <= head;
                        if (head == '0)
                            bound_reg[dp] <= wxy_pkg::UNBOUND;
                    end
                    default:
                    begin
                        left_reg[dp] <= left_dec;
                        if (left_dec == '0)
                            bound_reg[dp] <= wxy_pkg::UNBOUND;
                    end
                endcase
            end
            if (cmd.adv_prio)
                prio_reg <= (prio_reg == 3'(NP - 1)) ? '0 : prio_reg + 3'd1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.push || cmd.drive || cmd.none)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            rsp_reg <= '{kind: wxy_pkg::KIND_PUSH, push_refused: !push_ok,
                         out_port: 3'd0, src_port: 3'd0, out_flit: 16'd0, last: 1'b1};
        end
        else if (cmd.drive)
        begin
            rsp_reg <= '{kind: wxy_pkg::KIND_FWD, push_refused: 1'b0,
                         out_port: bound_reg[dp], src_port: dp,
                         out_flit: 16'(head), last: cmd.last};
        end
        else if (cmd.none)
        begin
            rsp_reg <= '{kind: wxy_pkg::KIND_NONE, push_refused: 1'b0,
                         out_port: 3'd0, src_port: 3'd0, out_flit: 16'd0, last: 1'b1};
        end
    end

    assign rsp            = rsp_reg;
    assign rsp_valid      = rsp_valid_reg;
    assign sts.req_op     = req.opcode;
    assign sts.out_free   = out_free;
    assign sts.prio       = prio_reg;
    assign sts.drive_mask = drive_mask;

endmodule

`default_nettype wire

### rtl/wxy_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wxy_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire wxy_pkg::sts_t sts,
    output wxy_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUSH   = 3'd1;
    localparam logic [2:0] S_ARB_RD = 3'd2;
    localparam logic [2:0] S_ARB    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DRV_RD = 3'd5;
    localparam logic [2:0] S_DRV    = 3'd6;
    localparam logic [2:0] S_NONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [4:0] mask_reg;
    logic [4:0] mask_next;
    logic [2:0] port_reg;
    logic [2:0] port_next;
    logic [4:0] rest;

    // lowest set port of a mask
    function automatic logic [2:0] first_port(input logic [4:0] m);
        logic [2:0] r;
        r = '0;
        for (int i = 4; i >= 0; i--)
        begin
            if (m[i])
                r = 3'(i);
        end
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        port_next  = port_reg;
        cmd        = '0;
        rest       = mask_reg;
        rest[port_reg] = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = (sts.req_op == wxy_pkg::OP_TICK) ? S_ARB_RD : S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ARB_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.port   = sts.prio;
                state_next = S_ARB;
            end
            S_ARB:
            begin
                cmd.arb    = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                mask_next = sts.drive_mask;
                if (sts.drive_mask == '0)
                    state_next = S_NONE;
                else
                begin
                    port_next  = first_port(sts.drive_mask);
                    state_next = S_DRV_RD;
                end
            end
            S_DRV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.port   = port_reg;
                state_next = S_DRV;
            end
            S_DRV:
            begin
                cmd.port = port_reg;
                if (sts.out_free)
                begin
                    cmd.drive = 1'b1;
                    cmd.last  = (rest == '0);
                    mask_next = rest;
                    if (rest == '0)
                    begin
                        cmd.adv_prio = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        port_next  = first_port(rest);
                        state_next = S_DRV_RD;
                    end
                end
            end
            S_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.none     = 1'b1;
                    cmd.adv_prio = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mask_reg  <= '0;
            port_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            port_reg  <= port_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

### rtl/wormhole_xy_mesh_router.sv
// five-port wormhole mesh router with xy routing, one input queue per port
// request channel (req_valid/req_stall/req): a push request appends in_flit to
// the queue of in_port and answers with one result of kind push; a tick request
// arbitrates the round-robin port, then forwards at most one flit per bound
// input in port order, one result each, or a single result of kind none
// result channel (rsp_valid/rsp_stall/rsp): last marks the final result of a request
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): router x at index 0,
// router y at index 1; always ready, write only while no request is in flight
// steps: a push passes S_PUSH, which waits for a free result register; a tick passes
// S_ARB_RD, S_ARB, S_SCAN, then S_DRV_RD and S_DRV per forwarded flit (S_NONE if none),
// set by the single read port of the shared queue memory, one head read per flit
// one request in flight at a time; req_stall stays high until its last result
// has been loaded into the result register
// a stalled result holds in the output register and the sequencer waits
// reset: all queues empty, no port bound, round-robin pointer at the local port,
// coordinates zero; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module wormhole_xy_mesh_router #(
    parameter int FIFO_DEPTH = wxy_pkg::FIFO_DEPTH_DEF,
    parameter int FLIT_WIDTH = wxy_pkg::FLIT_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_stall,
    input  wire wxy_pkg::req_t                    req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_stall,
    output wxy_pkg::rsp_t                         rsp,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wxy_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [3:0]                       cfg_data
);

    wxy_pkg::cmd_t cmd;
    wxy_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    wxy_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // queues, binding state and result register
    wxy_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .FLIT_WIDTH (FLIT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

### rtl/wxy_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wormhole_xy_mesh_router_macros.svh"

module wxy_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire wxy_pkg::rsp_t rsp
);

    // a held result keeps its value
    `WXY_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

    // one request in flight: an accepted request blocks the next cycle
    `WXY_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall, "request accepted while busy")

    // push answers and empty ticks end their request
    `WXY_ASSERT_NOW(a_single_last, rsp_valid && (rsp.kind != wxy_pkg::KIND_FWD), rsp.last, "single result without last")

    // only forwarded flits carry routing fields
    `WXY_ASSERT_NOW(a_zero_fields, rsp_valid && (rsp.kind != wxy_pkg::KIND_FWD), (rsp.out_port == 3'd0) && (rsp.src_port == 3'd0) && (rsp.out_flit == 16'd0), "non-forward result has routing fields")

endmodule

bind wormhole_xy_mesh_router wxy_checker u_chk (.*);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wxy_pkg::*;

    localparam int DEPTH = 16;
    localparam int RAND_ITEMS = 220;
    localparam int MAX_CYCLES = 400000;
    localparam int HDR_WAIT = -2;
    localparam int SIZE_WAIT = -1;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [3:0] cfg_data;

    wormhole_xy_mesh_router u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predicted router state
    logic [3:0] my_x, my_y;
    logic [15:0] queue_mem [5][DEPTH];
    int queue_cnt [5];
    int queue_rd [5];
    logic [2:0] bound_to [5];
    int flits_due [5];
    int rr_port;

    rsp_t expected_rsp [$];
    int mismatches;
    int cycle_cnt;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_rsp;
    int hold_cycles;

    // directed requests
    typedef struct {
        req_t r;
        bit typed;
        rsp_t want;
    } dir_row_t;
    dir_row_t dir_rows [$];

    function automatic logic [2:0] xy_route(input logic [15:0] f);
        logic [3:0] tx, ty;
        tx = f[7:4];
        ty = f[3:0];
        if (my_x == tx)
        begin
            if (my_y == ty) return PORT_LOCAL;
            return (my_y > ty) ? PORT_SOUTH : PORT_NORTH;
        end
        return (my_x > tx) ? PORT_WEST : PORT_EAST;
    endfunction

    task automatic predict_router(input req_t r);
        rsp_t o;
        int n;
        int p;
        bit taken;
        logic [2:0] tgt;
        logic [15:0] f;
        n = 0;
        o = '0;
        if (r.opcode == OP_PUSH)
        begin
            o.kind = KIND_PUSH;
            o.push_refused = 1'b1;
            o.last = 1'b1;
            if (r.in_port < 5 && queue_cnt[r.in_port] < DEPTH)
            begin
                queue_mem[r.in_port][(queue_rd[r.in_port] + queue_cnt[r.in_port]) % DEPTH] =
                    r.in_flit;
                queue_cnt[r.in_port]++;
                o.push_refused = 1'b0;
            end
            expected_rsp.push_back(o);
            return;
        end
        // arbitration of the round-robin port
        if (queue_cnt[rr_port] > 0 && bound_to[rr_port] == UNBOUND)
        begin
            tgt = xy_route(queue_mem[rr_port][queue_rd[rr_port]]);
            taken = 0;
            for (p = 0; p < 5; p++)
                if (bound_to[p] == tgt) taken = 1;
            if (!taken)
            begin
                bound_to[rr_port] = tgt;
                flits_due[rr_port] = HDR_WAIT;
            end
        end
        // crossbar
        for (p = 0; p < 5; p++)
        begin
            if (bound_to[p] == UNBOUND || queue_cnt[p] == 0) continue;
            if (r.out_full_mask[bound_to[p]]) continue;
            f = queue_mem[p][queue_rd[p]];
            if (flits_due[p] == HDR_WAIT) flits_due[p] = SIZE_WAIT;
            else if (flits_due[p] == SIZE_WAIT) flits_due[p] = f;
            else flits_due[p]--;
            queue_rd[p] = (queue_rd[p] + 1) % DEPTH;
            queue_cnt[p]--;
            o = '0;
            o.kind = KIND_FWD;
            o.out_port = bound_to[p];
            o.src_port = p[2:0];
            o.out_flit = f;
            if (flits_due[p] == 0) bound_to[p] = UNBOUND;
            expected_rsp.push_back(o);
            n++;
        end
        rr_port = (rr_port + 1) % 5;
        if (n == 0)
        begin
            o = '0;
            o.kind = KIND_NONE;
            o.last = 1'b1;
            expected_rsp.push_back(o);
        end
        else
        begin
            expected_rsp[expected_rsp.size() - 1].last = 1'b1;
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > MAX_CYCLES)
            begin
                $display("** wormhole_xy_mesh_router: FAILED **");
                $finish;
            end
        end
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", rsp);
            end
            else
            begin
                if (rsp !== expected_rsp[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p",
                                 expected_rsp[0], rsp);
                end
                void'(expected_rsp.pop_front());
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_rsp)
        begin
            rsp_stall <= 1'b1;
            if (hold_cycles > 0) hold_cycles--;
            else hold_rsp = 0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // valid stays up after acceptance until the next request or an idle cycle drops it
    task automatic send_req(input req_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predict_router(r);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROUTER_X) my_x = val;
        else my_y = val;
        @(posedge clk);
    endtask

    function automatic req_t mk_push(input int p, input logic [15:0] f);
        req_t r;
        r = '0;
        r.opcode = OP_PUSH;
        r.in_port = p[2:0];
        r.in_flit = f;
        return r;
    endfunction

    function automatic req_t mk_tick(input logic [4:0] m);
        req_t r;
        r = '0;
        r.opcode = OP_TICK;
        r.out_full_mask = m;
        return r;
    endfunction

    function automatic dir_row_t row(input req_t r, input bit typed, input rsp_t w);
        dir_row_t d;
        d.r = r;
        d.typed = typed;
        d.want = w;
        return d;
    endfunction

    // random packet with small payload, pushed to one port
    task automatic push_packet(input int p, input int len);
        int k;
        logic [15:0] hdr;
        hdr = $urandom;
        if ($urandom_range(3) == 0) hdr[7:0] = {my_x, my_y};
        send_req(mk_push(p, hdr));
        send_req(mk_push(p, len[15:0]));
        for (k = 0; k < len; k++) send_req(mk_push(p, $urandom));
    endtask

    task automatic tick_run(input int cnt);
        int k;
        logic [4:0] m;
        for (k = 0; k < cnt; k++)
        begin
            m = ($urandom_range(3) == 0) ? $urandom : 5'd0;
            send_req(mk_tick(m));
        end
    endtask

    task automatic random_phase(input int items_goal);
        int sent;
        int before_cnt;
        sent = 0;
        while (sent < items_goal)
        begin
            case ($urandom_range(9))
                0: begin
                    // noise: any port code, any flit
                    send_req(mk_push($urandom_range(7), $urandom));
                    sent++;
                end
                1, 2, 3, 4: begin
                    before_cnt = $urandom_range(3);
                    push_packet($urandom_range(4), before_cnt);
                    sent += before_cnt + 2;
                end
                default: begin
                    before_cnt = $urandom_range(1, 6);
                    tick_run(before_cnt);
                    sent += before_cnt;
                end
            endcase
        end
        // flush the queues with free-running ticks
        repeat (12) send_req(mk_tick(5'd0));
    endtask

    initial
    begin
        int i;
        int k;
        rsp_t w;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_rsp = 0;
        hold_cycles = 0;
        my_x = 0;
        my_y = 0;
        rr_port = 4;
        for (i = 0; i < 5; i++)
        begin
            queue_cnt[i] = 0;
            queue_rd[i] = 0;
            bound_to[i] = UNBOUND;
            flits_due[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick after reset, bad ports, extremes, size zero
        w = '0; w.kind = KIND_NONE; w.last = 1'b1;
        dir_rows.push_back(row(mk_tick(5'h1f), 1, w));
        w = '0; w.kind = KIND_PUSH; w.push_refused = 1'b1; w.last = 1'b1;
        dir_rows.push_back(row(mk_push(5, 16'hffff), 1, w));
        dir_rows.push_back(row(mk_push(7, 16'h0000), 1, w));
        w.push_refused = 1'b0;
        dir_rows.push_back(row(mk_push(4, 16'h0000), 1, w)); // header to self
        dir_rows.push_back(row(mk_push(4, 16'h0000), 1, w)); // size zero
        dir_rows.push_back(row(mk_push(0, 16'hffff), 1, w)); // header far east
        dir_rows.push_back(row(mk_push(0, 16'h0001), 1, w));
        dir_rows.push_back(row(mk_push(0, 16'hffff), 1, w));
        for (i = 0; i < 8; i++) dir_rows.push_back(row(mk_tick(i == 3 ? 5'h1f : 5'h00), 0, w));
        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].typed)
            begin
                send_req(dir_rows[i].r);
                if (expected_rsp[expected_rsp.size() - 1] !== dir_rows[i].want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("directed row %0d: prediction disagrees", i);
                end
            end
            else
            begin
                send_req(dir_rows[i].r);
            end
        end
        // fill a queue to overflow
        for (k = 0; k < DEPTH + 1; k++) send_req(mk_push(1, $urandom));
        repeat (20) send_req(mk_tick(5'd0));
        drain_results();

        // corners, middle and random points of the coordinate range, through all idle mixes
        write_reg(CFG_ROUTER_X, 4'hf);
        write_reg(CFG_ROUTER_Y, 4'h0);
        random_phase(RAND_ITEMS / 5);
        drain_results();

        send_idle_pct = 58;
        write_reg(CFG_ROUTER_X, 4'h0);
        write_reg(CFG_ROUTER_Y, 4'hf);
        random_phase(RAND_ITEMS / 5);
        drain_results();

        send_idle_pct = 0;
        recv_stall_pct = 58;
        write_reg(CFG_ROUTER_X, 4'h7);
        write_reg(CFG_ROUTER_Y, 4'h8);
        random_phase(RAND_ITEMS / 5);
        drain_results();

        send_idle_pct = 14;
        recv_stall_pct = 14;
        write_reg(CFG_ROUTER_X, $urandom);
        write_reg(CFG_ROUTER_Y, $urandom);
        random_phase(RAND_ITEMS / 5);
        drain_results();

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        hold_rsp = 1;
        random_phase(RAND_ITEMS / 5);
        drain_results();
        repeat (40) @(posedge clk);

        if (mismatches == 0 && expected_rsp.size() == 0)
        begin
            $display("** wormhole_xy_mesh_router: PASSED **");
        end
        else
        begin
            $display("** wormhole_xy_mesh_router: FAILED **");
        end
        $finish;
    end
endmodule
